// ===== design/assert_macros.svh =====
// Assertion macros used by the navigator top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define LPTN_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Same-cycle implication checked outside reset.
`define LPTN_ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ===== design/lptn_pkg.sv =====
// Types, codes and helper functions of the LPT code navigator.
package lptn_pkg;

   localparam int MAX_LEVELS = 16;
   localparam int SIGNS_W    = 16;
   localparam int LEN_W      = 6;
   localparam int LEVEL_W    = 5;

   typedef logic [2:0]          op_type;
   typedef logic [1:0]          status_type;
   typedef logic [LEN_W-1:0]    len_type;
   typedef logic [LEVEL_W-1:0]  level_type;
   typedef logic signed [2:0]   perm_type;
   typedef logic [SIGNS_W-1:0]  signs_type;

   localparam op_type OP_CHILD0    = 3'd0;
   localparam op_type OP_CHILD1    = 3'd1;
   localparam op_type OP_PARENT    = 3'd2;
   localparam op_type OP_NEIGHBOR0 = 3'd3;
   localparam op_type OP_NEIGHBOR1 = 3'd4;
   localparam op_type OP_NEIGHBOR2 = 3'd5;

   localparam status_type STATUS_OK          = 2'd0;
   localparam status_type STATUS_OUT_OF_BNDS = 2'd1;
   localparam status_type STATUS_UNSUPPORTED = 2'd2;

   localparam perm_type PERM_X_POS = 3'sd1;
   localparam perm_type PERM_Y_POS = 3'sd2;
   localparam perm_type PERM_Y_NEG = -3'sd2;

   // Result of the edge-0 level search.
   typedef struct packed {
      logic      found;
      signs_type flip;
   } scan_result_type;

   function automatic logic names_y(input perm_type p);
      return (p == PERM_Y_POS) || (p == PERM_Y_NEG);
   endfunction

   // Negation wraps within three bits.
   function automatic perm_type neg_perm(input perm_type p);
      return perm_type'(~p + 3'sd1);
   endfunction

   // Ones below level n.
   function automatic signs_type level_mask(input level_type n);
      signs_type m;
      for (int i = 0; i < SIGNS_W; i++) begin
         m[i] = (level_type'(i) < n);
      end
      return m;
   endfunction

   // Single bit at level lv, none when lv lies past the sign fields.
   function automatic signs_type level_bit(input level_type lv);
      signs_type b;
      for (int i = 0; i < SIGNS_W; i++) begin
         b[i] = (level_type'(i) == lv);
      end
      return b;
   endfunction

endpackage

// ===== design/lptn_scan.sv =====
// Edge-0 search: finds the deepest level whose sign differs and builds the flip span.
module lptn_scan (
   input  lptn_pkg::signs_type       diff,
   input  lptn_pkg::signs_type       lvl_mask,
   output lptn_pkg::scan_result_type result
);

   lptn_pkg::signs_type smear;

   // Smear the top set bit downward; shifting by one then gives the levels below it.
   always_comb begin
      smear = diff;
      smear = smear | (smear >> 1);
      smear = smear | (smear >> 2);
      smear = smear | (smear >> 4);
      smear = smear | (smear >> 8);
      result.found = |diff;
      result.flip  = lvl_mask & ~(smear >> 1);
   end

endmodule

// ===== design/lpt_code_navigator.sv =====
// Top level of the LPT code navigator: decode, level search and result stages.
//
//   channel   ports            handshake
//   request   start, req_*     taken when start is high and busy is low
//   response  rsp_valid, rsp_* one-cycle strobe, never held off
//
// One item is taken every cycle; busy stays low.
// Each result passes through the decode, search and assemble registers in that order.
// Reset clears the stage valid bits only; nothing is in flight afterwards.
// No stall exists: the response side takes every strobe.
`include "assert_macros.svh"

module lpt_code_navigator (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  lptn_pkg::op_type     req_op,
   input  lptn_pkg::len_type    req_level_len,
   input  lptn_pkg::perm_type   req_perm_first,
   input  lptn_pkg::perm_type   req_perm_second,
   input  lptn_pkg::signs_type  req_orth_x_signs,
   input  lptn_pkg::signs_type  req_orth_y_signs,
   output logic                 rsp_valid,
   output lptn_pkg::status_type rsp_status,
   output lptn_pkg::len_type    rsp_out_level_len,
   output lptn_pkg::perm_type   rsp_out_perm_first,
   output lptn_pkg::perm_type   rsp_out_perm_second,
   output lptn_pkg::signs_type  rsp_out_orth_x_signs,
   output lptn_pkg::signs_type  rsp_out_orth_y_signs
);

   // ---------------- stage 1: decode ----------------
   logic                  s1_valid_ff;
   lptn_pkg::status_type  s1_status_ff,   s1_status_in;
   lptn_pkg::len_type     s1_len_ff,      s1_len_in;
   lptn_pkg::perm_type    s1_r0_ff,       s1_r0_in;
   lptn_pkg::perm_type    s1_r1_ff,       s1_r1_in;
   lptn_pkg::signs_type   s1_xs_ff,       s1_ys_ff;
   lptn_pkg::signs_type   s1_put_ff,      s1_put_in;
   logic                  s1_px_ff,       s1_px_in;
   logic                  s1_py_ff,       s1_py_in;
   logic                  s1_scan_ff,     s1_scan_in;
   logic                  s1_scan_y_ff,   s1_scan_y_in;
   lptn_pkg::signs_type   s1_diff_ff,     s1_diff_in;
   lptn_pkg::signs_type   s1_lmask_ff,    s1_lmask_in;
   lptn_pkg::signs_type   s1_omask_ff,    s1_omask_in;

   lptn_pkg::level_type   n;
   lptn_pkg::level_type   nm1;
   logic                  l;
   lptn_pkg::perm_type    p0, p1, pi;
   lptn_pkg::signs_type   kind_vec;
   logic                  kind;
   logic [lptn_pkg::LEN_W:0] grown;
   lptn_pkg::signs_type   axis_vec;

   assign busy = 1'b0;

   always_comb begin
      p0  = req_perm_first;
      p1  = req_perm_second;
      n   = req_level_len[lptn_pkg::LEN_W-1:1];
      l   = req_level_len[0];
      nm1 = n - lptn_pkg::level_type'(1);

      // child type: sign of entry l* against the last orthant on its axis
      pi       = l ? p0 : p1;
      kind_vec = lptn_pkg::names_y(pi) ? req_orth_y_signs : req_orth_x_signs;
      kind     = (n == '0) ? p0[2] : (pi[2] != kind_vec[nm1[3:0]]);

      grown    = {1'b0, req_level_len} + 7'd1;
      axis_vec = lptn_pkg::names_y(p0) ? req_orth_y_signs : req_orth_x_signs;

      s1_status_in = lptn_pkg::STATUS_OK;
      s1_len_in    = req_level_len;
      s1_r0_in     = p0;
      s1_r1_in     = p1;
      s1_put_in    = '0;
      s1_scan_in   = 1'b0;
      s1_scan_y_in = 1'b0;
      s1_diff_in   = '0;
      s1_lmask_in  = lptn_pkg::level_mask(n);

      case (req_op)
         lptn_pkg::OP_CHILD0, lptn_pkg::OP_CHILD1: begin
            if (grown[lptn_pkg::LEN_W:1] > 6'(lptn_pkg::MAX_LEVELS)) begin
               s1_status_in = lptn_pkg::STATUS_OUT_OF_BNDS;
            end else begin
               s1_len_in = grown[lptn_pkg::LEN_W-1:0];
               if (req_op == lptn_pkg::OP_CHILD1) begin
                  if (!l) begin
                     s1_r0_in = lptn_pkg::neg_perm(p1);
                     s1_r1_in = p0;
                  end else begin
                     s1_r1_in = lptn_pkg::neg_perm(p1);
                  end
               end
               if (l) begin
                  s1_put_in = lptn_pkg::level_bit(n);
               end
            end
         end
         lptn_pkg::OP_PARENT: begin
            if (req_level_len == '0) begin
               s1_status_in = lptn_pkg::STATUS_OUT_OF_BNDS;
            end else begin
               s1_len_in = req_level_len - lptn_pkg::len_type'(1);
               if (kind) begin
                  if (l) begin
                     s1_r0_in = p1;
                     s1_r1_in = lptn_pkg::neg_perm(p0);
                  end else begin
                     s1_r1_in = lptn_pkg::neg_perm(p1);
                  end
               end
            end
         end
         lptn_pkg::OP_NEIGHBOR0: begin
            s1_r0_in     = lptn_pkg::neg_perm(p0);
            s1_scan_in   = 1'b1;
            s1_scan_y_in = lptn_pkg::names_y(p0);
            s1_diff_in   = (axis_vec ^ {lptn_pkg::SIGNS_W{p0[2]}}) & s1_lmask_in;
         end
         lptn_pkg::OP_NEIGHBOR1: begin
            s1_r0_in = p1;
            s1_r1_in = (kind && l) ? lptn_pkg::neg_perm(p0) : p0;
         end
         lptn_pkg::OP_NEIGHBOR2: begin
            if (kind && !l) begin
               s1_r1_in = lptn_pkg::neg_perm(p1);
               if (n != '0) begin
                  s1_put_in = lptn_pkg::level_bit(nm1);
               end
            end else begin
               s1_status_in = lptn_pkg::STATUS_UNSUPPORTED;
            end
         end
         default: begin
            s1_status_in = lptn_pkg::STATUS_UNSUPPORTED;
         end
      endcase

      if (n > lptn_pkg::level_type'(lptn_pkg::MAX_LEVELS)) begin
         s1_status_in = lptn_pkg::STATUS_OUT_OF_BNDS;
      end

      // orthant of the new level: image of (1,1) under the permutation
      s1_px_in    = !(s1_r0_in == lptn_pkg::PERM_X_POS || s1_r1_in == lptn_pkg::PERM_X_POS);
      s1_py_in    = !(s1_r0_in == lptn_pkg::PERM_Y_POS || s1_r1_in == lptn_pkg::PERM_Y_POS);
      s1_omask_in = lptn_pkg::level_mask(s1_len_in[lptn_pkg::LEN_W-1:1]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= start && !busy;
      end
      s1_status_ff <= s1_status_in;
      s1_len_ff    <= s1_len_in;
      s1_r0_ff     <= s1_r0_in;
      s1_r1_ff     <= s1_r1_in;
      s1_xs_ff     <= req_orth_x_signs;
      s1_ys_ff     <= req_orth_y_signs;
      s1_put_ff    <= s1_put_in;
      s1_px_ff     <= s1_px_in;
      s1_py_ff     <= s1_py_in;
      s1_scan_ff   <= s1_scan_in;
      s1_scan_y_ff <= s1_scan_y_in;
      s1_diff_ff   <= s1_diff_in;
      s1_lmask_ff  <= s1_lmask_in;
      s1_omask_ff  <= s1_omask_in;
   end

   // ---------------- stage 2: level search ----------------
   lptn_pkg::scan_result_type scan;

   logic                  s2_valid_ff;
   lptn_pkg::status_type  s2_status_ff, s2_status_in;
   lptn_pkg::len_type     s2_len_ff;
   lptn_pkg::perm_type    s2_r0_ff, s2_r1_ff;
   lptn_pkg::signs_type   s2_xs_ff, s2_xs_in;
   lptn_pkg::signs_type   s2_ys_ff, s2_ys_in;
   lptn_pkg::signs_type   s2_put_ff;
   logic                  s2_px_ff, s2_py_ff;
   lptn_pkg::signs_type   s2_omask_ff;

   lptn_scan u_scan (
      .diff     (s1_diff_ff),
      .lvl_mask (s1_lmask_ff),
      .result   (scan)
   );

   always_comb begin
      s2_status_in = s1_status_ff;
      s2_xs_in     = s1_xs_ff;
      s2_ys_in     = s1_ys_ff;
      if (s1_scan_ff) begin
         // no level turns back towards the base square: neighbour lies outside
         if (!scan.found && s1_status_ff == lptn_pkg::STATUS_OK) begin
            s2_status_in = lptn_pkg::STATUS_OUT_OF_BNDS;
         end
         if (s1_scan_y_ff) begin
            s2_ys_in = s1_ys_ff ^ scan.flip;
         end else begin
            s2_xs_in = s1_xs_ff ^ scan.flip;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_status_ff <= s2_status_in;
      s2_len_ff    <= s1_len_ff;
      s2_r0_ff     <= s1_r0_ff;
      s2_r1_ff     <= s1_r1_ff;
      s2_xs_ff     <= s2_xs_in;
      s2_ys_ff     <= s2_ys_in;
      s2_put_ff    <= s1_put_ff;
      s2_px_ff     <= s1_px_ff;
      s2_py_ff     <= s1_py_ff;
      s2_omask_ff  <= s1_omask_ff;
   end

   // ---------------- stage 3: assemble result ----------------
   logic                  rsp_valid_ff;
   lptn_pkg::status_type  rsp_status_ff;
   lptn_pkg::len_type     rsp_len_ff,   rsp_len_in;
   lptn_pkg::perm_type    rsp_r0_ff,    rsp_r0_in;
   lptn_pkg::perm_type    rsp_r1_ff,    rsp_r1_in;
   lptn_pkg::signs_type   rsp_xs_ff,    rsp_xs_in;
   lptn_pkg::signs_type   rsp_ys_ff,    rsp_ys_in;
   logic                  ok;

   always_comb begin
      ok         = (s2_status_ff == lptn_pkg::STATUS_OK);
      rsp_xs_in  = ((s2_xs_ff & ~s2_put_ff) | (s2_px_ff ? s2_put_ff : '0)) & s2_omask_ff;
      rsp_ys_in  = ((s2_ys_ff & ~s2_put_ff) | (s2_py_ff ? s2_put_ff : '0)) & s2_omask_ff;
      rsp_len_in = s2_len_ff;
      rsp_r0_in  = s2_r0_ff;
      rsp_r1_in  = s2_r1_ff;
      if (!ok) begin
         rsp_xs_in  = '0;
         rsp_ys_in  = '0;
         rsp_len_in = '0;
         rsp_r0_in  = '0;
         rsp_r1_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= s2_valid_ff;
      end
      rsp_status_ff <= s2_status_ff;
      rsp_len_ff    <= rsp_len_in;
      rsp_r0_ff     <= rsp_r0_in;
      rsp_r1_ff     <= rsp_r1_in;
      rsp_xs_ff     <= rsp_xs_in;
      rsp_ys_ff     <= rsp_ys_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_out_level_len    = rsp_len_ff;
   assign rsp_out_perm_first   = rsp_r0_ff;
   assign rsp_out_perm_second  = rsp_r1_ff;
   assign rsp_out_orth_x_signs = rsp_xs_ff;
   assign rsp_out_orth_y_signs = rsp_ys_ff;

   // ---------------- checks ----------------
   `LPTN_ASSERT_IMPLY(a_fail_zero,
      rsp_valid && rsp_status != lptn_pkg::STATUS_OK,
      rsp_out_level_len == '0 && rsp_out_perm_first == '0 && rsp_out_perm_second == '0
         && rsp_out_orth_x_signs == '0 && rsp_out_orth_y_signs == '0,
      "failed item carries a non-zero code")
   `LPTN_ASSERT_IMPLY(a_unused_levels,
      rsp_valid && rsp_status == lptn_pkg::STATUS_OK,
      ((rsp_out_orth_x_signs | rsp_out_orth_y_signs)
         & ~lptn_pkg::level_mask(rsp_out_level_len[lptn_pkg::LEN_W-1:1])) == '0,
      "sign bits set beyond the result depth")
   `LPTN_ASSERT_IMPLY(a_depth_bound,
      rsp_valid && rsp_status == lptn_pkg::STATUS_OK,
      rsp_out_level_len[lptn_pkg::LEN_W-1:1] <= 5'(lptn_pkg::MAX_LEVELS),
      "result deeper than the level limit")
   `LPTN_ASSERT(a_pipe_valid,
      rsp_valid == $past(s2_valid_ff) || $past(reset),
      "result strobe out of step with the search stage")

endmodule
